@@ hdl/efg_pkg.sv @@
// Package for the event flag group block.
// Holds the shared constants, operation, status and back-end state codes, and the command struct.
// No dependencies.
package efg_pkg;

  localparam int unsigned FlagBitsDef   = 32;
  localparam int unsigned MaxWaitersDef = 8;
  localparam int unsigned TaskW         = 3;
  localparam int unsigned OpW           = 2;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QPtrW         = $clog2(QueueDepth);
  localparam int unsigned QCntW         = $clog2(QueueDepth + 1);

  typedef enum logic [OpW-1:0] {
    OpWait    = 2'd0,
    OpTry     = 2'd1,
    OpNotify  = 2'd2,
    OpDestroy = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StSatisfied    = 3'd0,
    StNotSatisfied = 3'd1,
    StQueued       = 3'd2,
    StWoken        = 3'd3,
    StReleased     = 3'd4,
    StFull         = 3'd5,
    StDone         = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkWalk,
    BkFlush
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic             is_check;
    logic [TaskW-1:0] task_id;
    logic             for_set;
    logic             all;
    logic             consume;
    logic             set_mode;
  } cmd_ctrl_t;

endpackage

@@ hdl/efg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module efg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/efg_front.sv @@
// Front end of the event flag group: accepts requests, decodes them and queues them.
// Depends on efg_pkg.
module efg_front #(
  parameter int unsigned FLAG_BITS = efg_pkg::FlagBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [efg_pkg::OpW-1:0]     op_i,
  input  logic [efg_pkg::TaskW-1:0]   task_id_i,
  input  logic                        wait_for_set_i,
  input  logic                        wait_all_i,
  input  logic                        consume_i,
  input  logic                        set_mode_i,
  input  logic [FLAG_BITS-1:0]        mask_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output efg_pkg::cmd_ctrl_t          head_ctrl_o,
  output logic [FLAG_BITS-1:0]        head_mask_o
);
  import efg_pkg::*;

  cmd_ctrl_t            ctrl_q [QueueDepth];
  logic [FLAG_BITS-1:0] mask_q [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     count_q, count_d;
  cmd_ctrl_t            in_ctrl;
  logic                 push, pop;

  always_comb begin
    in_ctrl.op       = op_e'(op_i);
    in_ctrl.is_check = (op_e'(op_i) == OpWait) || (op_e'(op_i) == OpTry);
    in_ctrl.task_id  = task_id_i;
    in_ctrl.for_set  = wait_for_set_i;
    in_ctrl.all      = wait_all_i;
    in_ctrl.consume  = consume_i;
    in_ctrl.set_mode = set_mode_i;
  end

  assign busy    = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign push    = start && !busy;
  assign pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctrl_q[wr_ptr_q] <= in_ctrl;
      mask_q[wr_ptr_q] <= mask_i;
    end
  end

  assign head_ctrl_o = ctrl_q[rd_ptr_q];
  assign head_mask_o = mask_q[rd_ptr_q];

endmodule

@@ hdl/efg_back.sv @@
// Back end of the event flag group: flag word, waiter table and result generation.
// Depends on efg_pkg and efg_ram.
module efg_back #(
  parameter int unsigned FLAG_BITS   = efg_pkg::FlagBitsDef,
  parameter int unsigned MAX_WAITERS = efg_pkg::MaxWaitersDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  input  efg_pkg::cmd_ctrl_t                head_ctrl_i,
  input  logic [FLAG_BITS-1:0]              head_mask_i,
  output logic                              pop_o,
  input  logic                              cfg_we_i,
  input  logic [FLAG_BITS-1:0]              initial_flags_i,
  output logic                              result_valid_o,
  output logic [efg_pkg::StatusW-1:0]       status_o,
  output logic [efg_pkg::TaskW-1:0]         result_task_o,
  output logic [FLAG_BITS-1:0]              result_flags_o,
  output logic [FLAG_BITS-1:0]              flags_now_o,
  output logic [$clog2(MAX_WAITERS+1)-1:0]  waiter_count_o,
  output logic                              last_o
);
  import efg_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WAITERS);
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned EW = TaskW + 3 + FLAG_BITS;

  back_state_e          state_q, state_d;
  logic [FLAG_BITS-1:0] flags_q, flags_d;
  logic [CW-1:0]        total_q, total_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d, idx_inc;
  logic [CW-1:0]        wp_q, wp_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, entry;

  logic [TaskW-1:0]     ent_task;
  logic                 ent_set, ent_all, ent_cons;
  logic [FLAG_BITS-1:0] ent_req;

  logic [FLAG_BITS-1:0] chk_req, chk_match, chk_flags;
  logic                 chk_set, chk_all, chk_cons, chk_ok;

  logic                 valid_q, valid_d;
  status_e              status_q, status_d;
  logic [TaskW-1:0]     task_q, task_d;
  logic [FLAG_BITS-1:0] rflags_q, rflags_d;
  logic [FLAG_BITS-1:0] fnow_q;
  logic [CW-1:0]        wcount_q;
  logic                 last_q, last_d;

  efg_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_WAITERS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(entry)
  );

  assign {ent_task, ent_set, ent_all, ent_cons, ent_req} = entry;
  assign idx_inc = idx_q + 1'b1;

  always_comb begin
    if (state_q == BkIdle) begin
      chk_req  = head_mask_i;
      chk_set  = head_ctrl_i.for_set;
      chk_all  = head_ctrl_i.all;
      chk_cons = head_ctrl_i.consume;
    end else begin
      chk_req  = ent_req;
      chk_set  = ent_set;
      chk_all  = ent_all;
      chk_cons = ent_cons;
    end
    chk_match = (chk_set ? flags_q : ~flags_q) & chk_req;
    chk_ok    = chk_all ? (chk_match == chk_req) : (|chk_match);
    chk_flags = flags_q;
    if (chk_ok && chk_cons) begin
      chk_flags = chk_set ? (flags_q & ~chk_req) : (flags_q | chk_req);
    end
  end

  always_comb begin
    state_d   = state_q;
    flags_d   = flags_q;
    total_d   = total_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    wp_d      = wp_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wp_q[AW-1:0];
    ram_wdata = entry;
    ram_raddr = (state_q == BkIdle) ? '0 : idx_inc[AW-1:0];
    valid_d   = 1'b0;
    status_d  = StDone;
    task_d    = '0;
    rflags_d  = '0;
    last_d    = 1'b0;

    case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          idx_d = '0;
          wp_d  = '0;
          cnt_d = total_q;
          if (head_ctrl_i.is_check) begin
            valid_d  = 1'b1;
            last_d   = 1'b1;
            task_d   = head_ctrl_i.task_id;
            rflags_d = chk_match;
            if (chk_ok) begin
              status_d = StSatisfied;
              flags_d  = chk_flags;
            end else if (head_ctrl_i.op == OpTry) begin
              status_d = StNotSatisfied;
            end else if (total_q == CW'(MAX_WAITERS)) begin
              status_d = StFull;
            end else begin
              status_d  = StQueued;
              ram_we    = 1'b1;
              ram_waddr = total_q[AW-1:0];
              ram_wdata = {head_ctrl_i.task_id, head_ctrl_i.for_set, head_ctrl_i.all,
                           head_ctrl_i.consume, head_mask_i};
              total_d   = total_q + 1'b1;
            end
          end else if (head_ctrl_i.op == OpNotify) begin
            flags_d = head_ctrl_i.set_mode ? (flags_q | head_mask_i)
                                           : (flags_q & ~head_mask_i);
            state_d = BkWalk;
          end else begin
            state_d = BkFlush;
          end
        end
      end
      BkWalk: begin
        if (idx_q < cnt_q) begin
          idx_d = idx_inc;
          if (chk_ok) begin
            valid_d  = 1'b1;
            status_d = StWoken;
            task_d   = ent_task;
            rflags_d = chk_match;
            flags_d  = chk_flags;
            total_d  = total_q - 1'b1;
          end else begin
            ram_we = 1'b1;
            wp_d   = wp_q + 1'b1;
          end
        end else begin
          valid_d = 1'b1;
          last_d  = 1'b1;
          state_d = BkIdle;
        end
      end
      BkFlush: begin
        if (idx_q < cnt_q) begin
          idx_d    = idx_inc;
          valid_d  = 1'b1;
          status_d = StReleased;
          task_d   = ent_task;
          rflags_d = ent_req;
          total_d  = total_q - 1'b1;
        end else begin
          valid_d = 1'b1;
          last_d  = 1'b1;
          state_d = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase

    if (cfg_we_i) begin
      flags_d = initial_flags_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      flags_q <= '0;
      total_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      wp_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flags_q <= flags_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      wp_q    <= wp_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    task_q   <= task_d;
    rflags_q <= rflags_d;
    fnow_q   <= flags_d;
    wcount_q <= total_d;
    last_q   <= last_d;
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign result_task_o  = task_q;
  assign result_flags_o = rflags_q;
  assign flags_now_o    = fnow_q;
  assign waiter_count_o = wcount_q;
  assign last_o         = last_q && valid_q;

endmodule

@@ hdl/event_flag_group_with_waiters.sv @@
// Top level of the event flag group with an ordered table of waiting tasks.
// Depends on efg_pkg, efg_front and efg_back.
//
// A request is taken at a rising edge with start high and busy low. It enters a
// two-entry command queue, so up to two requests can be taken while the back end
// is still working. Configuration is a single register: cfg_we_i loads
// initial_flags_i into the flag word; write it only while the block is idle.
//
// Results come out one per cycle at most, each marked by result_valid_o for a
// single cycle; last_o marks the final result of a request. A wait or try gives
// its one result through the command queue and the result registers, and is
// decided without leaving the idle state. Notify and destroy hold the back end
// while the walk reads the n queued waiters, one table entry per cycle from the
// waiter RAM. Destroy results arrive on consecutive cycles; notify has gaps for
// waiters that stay queued.
//
// Reset clears the flag word, the waiter count and the queue; table contents are
// left as they are. The receiver cannot stall, so results are never held.
module event_flag_group_with_waiters #(
  parameter int unsigned FLAG_BITS   = efg_pkg::FlagBitsDef,
  parameter int unsigned MAX_WAITERS = efg_pkg::MaxWaitersDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [efg_pkg::OpW-1:0]           op_i,
  input  logic [efg_pkg::TaskW-1:0]         task_id_i,
  input  logic                              wait_for_set_i,
  input  logic                              wait_all_i,
  input  logic                              consume_i,
  input  logic                              set_mode_i,
  input  logic [FLAG_BITS-1:0]              mask_i,
  input  logic                              cfg_we_i,
  input  logic [FLAG_BITS-1:0]              initial_flags_i,
  output logic                              result_valid_o,
  output logic [efg_pkg::StatusW-1:0]       status_o,
  output logic [efg_pkg::TaskW-1:0]         result_task_o,
  output logic [FLAG_BITS-1:0]              result_flags_o,
  output logic [FLAG_BITS-1:0]              flags_now_o,
  output logic [$clog2(MAX_WAITERS+1)-1:0]  waiter_count_o,
  output logic                              last_o
);
  import efg_pkg::*;

  cmd_ctrl_t            head_ctrl;
  logic [FLAG_BITS-1:0] head_mask;
  logic                 q_empty;
  logic                 q_pop;

  efg_front #(
    .FLAG_BITS(FLAG_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .task_id_i     (task_id_i),
    .wait_for_set_i(wait_for_set_i),
    .wait_all_i    (wait_all_i),
    .consume_i     (consume_i),
    .set_mode_i    (set_mode_i),
    .mask_i        (mask_i),
    .pop_i         (q_pop),
    .empty_o       (q_empty),
    .head_ctrl_o   (head_ctrl),
    .head_mask_o   (head_mask)
  );

  efg_back #(
    .FLAG_BITS  (FLAG_BITS),
    .MAX_WAITERS(MAX_WAITERS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_ctrl_i    (head_ctrl),
    .head_mask_i    (head_mask),
    .pop_o          (q_pop),
    .cfg_we_i       (cfg_we_i),
    .initial_flags_i(initial_flags_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .result_task_o  (result_task_o),
    .result_flags_o (result_flags_o),
    .flags_now_o    (flags_now_o),
    .waiter_count_o (waiter_count_o),
    .last_o         (last_o)
  );

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == StDone)) |-> last_o)
    else $error("Completion result without last marker.");

  a_queued_has_waiter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == StQueued)) |-> (waiter_count_o != '0))
    else $error("Queued result reports an empty waiter table.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (waiter_count_o <= ($clog2(MAX_WAITERS+1))'(MAX_WAITERS)))
    else $error("Waiter count exceeds table depth.");

  a_release_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == StReleased) && !cfg_we_i)
      |=> (!result_valid_o || $stable(flags_now_o)))
    else $error("Flag word changed during release.");

endmodule

@@ verif/tb.sv @@
// Testbench for event_flag_group_with_waiters: drives wait, try, notify and destroy
// requests, predicts every result with a flag word and waiter table of its own, and checks them.
// Depends on efg_pkg and the event_flag_group_with_waiters RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efg_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    op_e         op;
    logic [2:0]  task_id;
    logic        for_set;
    logic        wait_all;
    logic        consume;
    logic        set_mode;
    logic [31:0] mask;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  task_id;
    logic [31:0] match_bits;
    logic [31:0] flags;
    logic [3:0]  count;
    logic        is_last;
  } outcome_t;

  class flag_group_scoreboard;
    logic [31:0] flags;
    request_t    waiters[$];
    outcome_t    pending[$];
    int          errors;

    function new();
      flags = '0;
      errors = 0;
    endfunction

    function void load_flags(logic [31:0] value);
      flags = value;
    endfunction

    function bit evaluate(request_t r, output logic [31:0] hit);
      bit ok;
      hit = (r.for_set ? flags : ~flags) & r.mask;
      ok = r.wait_all ? (hit == r.mask) : (hit != '0);
      if (ok && r.consume) begin
        flags = r.for_set ? (flags & ~r.mask) : (flags | r.mask);
      end
      return ok;
    endfunction

    function void push(status_e s, logic [2:0] t, logic [31:0] bits);
      outcome_t o;
      o.status = s;
      o.task_id = t;
      o.match_bits = bits;
      o.flags = flags;
      o.count = 4'(waiters.size());
      o.is_last = 1'b0;
      pending.push_back(o);
    endfunction

    function void note_request(request_t r);
      logic [31:0] hit;
      request_t w;
      int i;
      case (r.op)
        OpWait, OpTry: begin
          if (evaluate(r, hit)) begin
            push(StSatisfied, r.task_id, hit);
          end else if (r.op == OpTry) begin
            push(StNotSatisfied, r.task_id, hit);
          end else if (waiters.size() >= MaxWaitersDef) begin
            push(StFull, r.task_id, hit);
          end else begin
            waiters.push_back(r);
            push(StQueued, r.task_id, hit);
          end
        end
        OpNotify: begin
          flags = r.set_mode ? (flags | r.mask) : (flags & ~r.mask);
          i = 0;
          while (i < waiters.size()) begin
            w = waiters[i];
            if (evaluate(w, hit)) begin
              waiters.delete(i);
              push(StWoken, w.task_id, hit);
            end else begin
              i++;
            end
          end
          push(StDone, '0, '0);
        end
        default: begin
          while (waiters.size() > 0) begin
            w = waiters.pop_front();
            push(StReleased, w.task_id, w.mask);
          end
          push(StDone, '0, '0);
        end
      endcase
      pending[pending.size()-1].is_last = 1'b1;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual status %0d task %0d",
                 $time, got.status, got.task_id);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("result_task", 32'(want.task_id), 32'(got.task_id));
      compare("result_flags", want.match_bits, got.match_bits);
      compare("flags_now", want.flags, got.flags);
      compare("waiter_count", 32'(want.count), 32'(got.count));
      compare("last", 32'(want.is_last), 32'(got.is_last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [2:0]  task_id_i;
  logic        wait_for_set_i;
  logic        wait_all_i;
  logic        consume_i;
  logic        set_mode_i;
  logic [31:0] mask_i;
  logic        cfg_we_i;
  logic [31:0] initial_flags_i;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [2:0]  result_task_o;
  logic [31:0] result_flags_o;
  logic [31:0] flags_now_o;
  logic [3:0]  waiter_count_o;
  logic        last_o;

  flag_group_scoreboard model = new();

  event_flag_group_with_waiters i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .task_id_i      (task_id_i),
    .wait_for_set_i (wait_for_set_i),
    .wait_all_i     (wait_all_i),
    .consume_i      (consume_i),
    .set_mode_i     (set_mode_i),
    .mask_i         (mask_i),
    .cfg_we_i       (cfg_we_i),
    .initial_flags_i(initial_flags_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .result_task_o  (result_task_o),
    .result_flags_o (result_flags_o),
    .flags_now_o    (flags_now_o),
    .waiter_count_o (waiter_count_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && result_valid_o === 1'b1) begin
      got.status = status_e'(status_o);
      got.task_id = result_task_o;
      got.match_bits = result_flags_o;
      got.flags = flags_now_o;
      got.count = waiter_count_o;
      got.is_last = last_o;
      model.check_result(got);
    end
  end

  initial begin
    int unsigned clk_count;
    clk_count = 0;
    while (clk_count < CycleLimit) begin
      @(posedge clk_i);
      clk_count++;
    end
    $display("event_flag_group_with_waiters verification failed");
    $finish;
  end

  function automatic request_t make_request(op_e op, logic [2:0] t, logic fs, logic wa,
                                            logic cons, logic sm, logic [31:0] mask);
    request_t r;
    r.op = op;
    r.task_id = t;
    r.for_set = fs;
    r.wait_all = wa;
    r.consume = cons;
    r.set_mode = sm;
    r.mask = mask;
    return r;
  endfunction

  function automatic logic [31:0] random_mask();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(15);
      5: return 32'h1 << $urandom_range(31);
      6: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t random_request();
    int unsigned pick;
    op_e op;
    pick = $urandom_range(99);
    if (pick < 40) op = OpWait;
    else if (pick < 60) op = OpTry;
    else if (pick < 92) op = OpNotify;
    else op = OpDestroy;
    return make_request(op, 3'($urandom_range(7)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)), random_mask());
  endfunction

  task automatic send(request_t r);
    start <= 1'b1;
    op_i <= r.op;
    task_id_i <= r.task_id;
    wait_for_set_i <= r.for_set;
    wait_all_i <= r.wait_all;
    consume_i <= r.consume;
    set_mode_i <= r.set_mode;
    mask_i <= r.mask;
    do @(posedge clk_i); while (busy !== 1'b0);
    model.note_request(r);
  endtask

  task automatic idle_gap(int unsigned pct);
    if (pct > 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < pct) @(posedge clk_i);
    end
  endtask

  task automatic drain(int unsigned extra);
    start <= 1'b0;
    do @(posedge clk_i); while (model.pending.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_flags(logic [31:0] value);
    cfg_we_i <= 1'b1;
    initial_flags_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model.load_flags(value);
  endtask

  initial begin
    request_t     directed[$];
    int unsigned  idle_pct[4];
    logic [31:0]  cfg_value[4];

    rst_ni = 1'b0;
    start = 1'b0;
    op_i = OpWait;
    task_id_i = '0;
    wait_for_set_i = 1'b0;
    wait_all_i = 1'b0;
    consume_i = 1'b0;
    set_mode_i = 1'b0;
    mask_i = '0;
    cfg_we_i = 1'b0;
    initial_flags_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_request(OpTry, 3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF));
    directed.push_back(make_request(OpTry, 3'd1, 1'b0, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(make_request(OpWait, 3'd2, 1'b0, 1'b0, 1'b1, 1'b0, 32'h1));
    directed.push_back(make_request(OpWait, 3'd1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h6));
    directed.push_back(make_request(OpWait, 3'd2, 1'b1, 1'b0, 1'b1, 1'b0, 32'h6));
    directed.push_back(make_request(OpWait, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h8));
    directed.push_back(make_request(OpNotify, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'h2));
    directed.push_back(make_request(OpNotify, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'hE));
    directed.push_back(make_request(OpNotify, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    for (int t = 0; t < 8; t++) begin
      directed.push_back(make_request(OpWait, t[2:0], 1'b1, 1'b1, t[0], 1'b0, 32'h8000_0000));
    end
    directed.push_back(make_request(OpWait, 3'd3, 1'b1, 1'b0, 1'b0, 1'b0, 32'h1));
    directed.push_back(make_request(OpTry, 3'd4, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0));
    directed.push_back(make_request(OpDestroy, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));
    directed.push_back(make_request(OpDestroy, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(make_request(OpNotify, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    directed.push_back(make_request(OpWait, 3'd6, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));
    directed.push_back(make_request(OpWait, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 32'h1));
    directed.push_back(make_request(OpWait, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h1));
    directed.push_back(make_request(OpNotify, 3'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'h1));
    foreach (directed[i]) send(directed[i]);

    idle_pct = '{0, 85, 24, 0};
    cfg_value = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom_range(15)};
    for (int phase = 0; phase < 4; phase++) begin
      drain(4);
      write_flags(cfg_value[phase]);
      for (int n = 0; n < 120; n++) begin
        send(random_request());
        if ($urandom_range(49) == 0) drain(0);
        else idle_gap(idle_pct[phase]);
      end
    end

    drain(DrainCycles);
    if (model.errors == 0) begin
      $display("event_flag_group_with_waiters verification clean");
    end else begin
      $display("event_flag_group_with_waiters verification failed");
    end
    $finish;
  end

endmodule
